>>> hw/rtl/sdrs_pkg.sv
// shared types and codes for the scan disk request scheduler
// used by sdrs_cell and scan_disk_request_scheduler_core, no dependencies
package sdrs_pkg;

  localparam int ADDR_W   = 10;
  localparam int CLIENT_W = 8;

  // input item kinds
  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [CLIENT_W-1:0] client;
    logic                wr;
  } entry_t;

  // running best candidate handed down the chain
  typedef struct packed {
    logic   found;
    entry_t ent;
  } best_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              append_en;
    logic              remove_en;
    logic [ADDR_W-1:0] head;
    entry_t            new_ent;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_PICK
  } state_t;

endpackage

>>> hw/rtl/sdrs_cell.sv
// one queue slot of the scheduler chain: holds a pending request and
// registers the nearest-up / nearest-down candidate seen so far; uses sdrs_pkg
module sdrs_cell #(
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic                  clk,
  input  sdrs_pkg::cell_ctl_t   ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [IDX_W-1:0]      rm_idx,
  input  sdrs_pkg::entry_t      nb_ent,
  input  sdrs_pkg::best_t       up_in,
  input  logic [IDX_W-1:0]      up_idx_in,
  input  sdrs_pkg::best_t       dn_in,
  input  logic [IDX_W-1:0]      dn_idx_in,
  output sdrs_pkg::entry_t      ent,
  output sdrs_pkg::best_t       up_out,
  output logic [IDX_W-1:0]      up_idx_out,
  output sdrs_pkg::best_t       dn_out,
  output logic [IDX_W-1:0]      dn_idx_out
);

  sdrs_pkg::entry_t ent_r, ent_nxt;
  sdrs_pkg::best_t  up_r, up_nxt, dn_r, dn_nxt;
  logic [IDX_W-1:0] up_idx_r, up_idx_nxt, dn_idx_r, dn_idx_nxt;
  logic             valid;
  logic             take_up, take_dn;

  assign valid = count > CNT_W'(CELL_IDX);

  // strict compare keeps the earlier arrival on equal addresses
  assign take_up = valid && (ent_r.addr >= ctl.head) &&
                   (!up_in.found || ent_r.addr < up_in.ent.addr);
  assign take_dn = valid && (ent_r.addr <= ctl.head) &&
                   (!dn_in.found || ent_r.addr > dn_in.ent.addr);

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.remove_en && (rm_idx <= IDX_W'(CELL_IDX))) begin
      // close the gap left by the removed item
      ent_nxt = nb_ent;
    end else if (ctl.append_en && (count == CNT_W'(CELL_IDX))) begin
      ent_nxt = ctl.new_ent;
    end
  end

  always_comb begin
    up_nxt     = up_in;
    up_idx_nxt = up_idx_in;
    dn_nxt     = dn_in;
    dn_idx_nxt = dn_idx_in;
    if (take_up) begin
      up_nxt     = '{found: 1'b1, ent: ent_r};
      up_idx_nxt = IDX_W'(CELL_IDX);
    end
    if (take_dn) begin
      dn_nxt     = '{found: 1'b1, ent: ent_r};
      dn_idx_nxt = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    ent_r    <= ent_nxt;
    up_r     <= up_nxt;
    up_idx_r <= up_idx_nxt;
    dn_r     <= dn_nxt;
    dn_idx_r <= dn_idx_nxt;
  end

  assign ent        = ent_r;
  assign up_out     = up_r;
  assign up_idx_out = up_idx_r;
  assign dn_out     = dn_r;
  assign dn_idx_out = dn_idx_r;

endmodule

>>> hw/rtl/scan_disk_request_scheduler_core.sv
// scan (elevator) disk request scheduler: sequencer plus a chain of sdrs_cell
// slots that both hold the pending queue and search it; uses sdrs_pkg
// result strobe: registered from ST_DECIDE when no dispatch search runs, and
// from ST_PICK after ST_SEARCH when one runs (one chain stage per cycle)
// one item at a time: taken only in ST_IDLE, busy high until its result is registered
// reset: synchronous active-low, empties the queue, head 0, upward sweep
module scan_disk_request_scheduler_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DISK_BLOCKS = 1024,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [sdrs_pkg::ADDR_W-1:0]   in_req_addr,
  input  logic [sdrs_pkg::CLIENT_W-1:0] in_req_client,
  input  logic                          in_req_write,
  output logic                          out_valid,
  output logic                          out_dispatched,
  output logic [sdrs_pkg::ADDR_W-1:0]   out_disp_addr,
  output logic [sdrs_pkg::CLIENT_W-1:0] out_disp_client,
  output logic                          out_disp_write,
  output logic                          out_done_valid,
  output logic [sdrs_pkg::CLIENT_W-1:0] out_done_client,
  output logic                          out_parked,
  output logic [sdrs_pkg::ADDR_W-1:0]   out_head_now,
  output logic                          out_dropped,
  output logic [CNT_W-1:0]              out_pending_now
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AW    = sdrs_pkg::ADDR_W;
  localparam int CW    = sdrs_pkg::CLIENT_W;
  localparam bit SAT_EN = DISK_BLOCKS < (1 << AW);
  localparam logic [AW-1:0] ADDR_MAX = SAT_EN ? AW'(DISK_BLOCKS - 1) : {AW{1'b1}};
  localparam logic [IDX_W-1:0] SRCH_LAST = IDX_W'(QUEUE_DEPTH - 2);

  sdrs_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic             going_up_r, going_up_nxt;
  logic             inflight_r, inflight_nxt;
  logic [CW-1:0]    busy_client_r, busy_client_nxt;
  logic [IDX_W-1:0] srch_cnt_r, srch_cnt_nxt;
  logic             drop_r, drop_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    done_client_r, done_client_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_disp_r, out_disp_nxt;
  sdrs_pkg::entry_t out_ent_r, out_ent_nxt;
  logic             out_done_r, out_done_nxt;
  logic [CW-1:0]    out_done_client_r, out_done_client_nxt;
  logic             out_parked_r, out_parked_nxt;
  logic [AW-1:0]    out_head_r, out_head_nxt;
  logic             out_drop_r, out_drop_nxt;
  logic [CNT_W-1:0] out_pend_r, out_pend_nxt;

  logic accept, need_search, fin_short, do_park, do_pick, full;
  logic use_up;
  sdrs_pkg::best_t     sel;
  logic [IDX_W-1:0]    sel_idx;
  sdrs_pkg::cell_ctl_t ctl;

  sdrs_pkg::entry_t ent_w    [QUEUE_DEPTH];
  sdrs_pkg::best_t  up_w     [QUEUE_DEPTH+1];
  sdrs_pkg::best_t  dn_w     [QUEUE_DEPTH+1];
  logic [IDX_W-1:0] up_idx_w [QUEUE_DEPTH+1];
  logic [IDX_W-1:0] dn_idx_w [QUEUE_DEPTH+1];

  // ---------------- sequencer ----------------
  assign full        = count_r >= CNT_W'(QUEUE_DEPTH);
  assign need_search = !inflight_r && (count_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdrs_pkg::ST_IDLE:   if (start) state_nxt = sdrs_pkg::ST_DECIDE;
      sdrs_pkg::ST_DECIDE: state_nxt = need_search ? sdrs_pkg::ST_SEARCH : sdrs_pkg::ST_IDLE;
      sdrs_pkg::ST_SEARCH: if (srch_cnt_r == SRCH_LAST) state_nxt = sdrs_pkg::ST_PICK;
      sdrs_pkg::ST_PICK:   state_nxt = sdrs_pkg::ST_IDLE;
      default:             state_nxt = sdrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    accept    = 1'b0;
    fin_short = 1'b0;
    do_park   = 1'b0;
    do_pick   = 1'b0;
    busy      = 1'b1;
    case (state_r)
      sdrs_pkg::ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      sdrs_pkg::ST_DECIDE: begin
        fin_short = !need_search;
        do_park   = !inflight_r && (count_r == '0);
      end
      sdrs_pkg::ST_SEARCH: ;
      sdrs_pkg::ST_PICK:   do_pick = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  // ---------------- chain of cells ----------------
  // keep the current direction while it has a candidate, otherwise reverse
  assign use_up  = going_up_r ? up_w[QUEUE_DEPTH].found : !dn_w[QUEUE_DEPTH].found;
  assign sel     = use_up ? up_w[QUEUE_DEPTH] : dn_w[QUEUE_DEPTH];
  assign sel_idx = use_up ? up_idx_w[QUEUE_DEPTH] : dn_idx_w[QUEUE_DEPTH];

  always_comb begin
    ctl.append_en      = accept && (in_kind == sdrs_pkg::KIND_REQ) && !full;
    ctl.remove_en      = do_pick;
    ctl.head           = head_r;
    ctl.new_ent.addr   = (in_req_addr > ADDR_MAX) ? ADDR_MAX : in_req_addr;
    ctl.new_ent.client = in_req_client;
    ctl.new_ent.wr     = in_req_write;
  end

  assign up_w[0]     = '0;
  assign dn_w[0]     = '0;
  assign up_idx_w[0] = '0;
  assign dn_idx_w[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sdrs_pkg::entry_t nb;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb = ent_w[i];
    end else begin : g_mid
      assign nb = ent_w[i+1];
    end

    sdrs_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .rm_idx     (sel_idx),
      .nb_ent     (nb),
      .up_in      (up_w[i]),
      .up_idx_in  (up_idx_w[i]),
      .dn_in      (dn_w[i]),
      .dn_idx_in  (dn_idx_w[i]),
      .ent        (ent_w[i]),
      .up_out     (up_w[i+1]),
      .up_idx_out (up_idx_w[i+1]),
      .dn_out     (dn_w[i+1]),
      .dn_idx_out (dn_idx_w[i+1])
    );
  end

  // ---------------- scheduler state ----------------
  always_comb begin
    count_nxt       = count_r;
    head_nxt        = head_r;
    going_up_nxt    = going_up_r;
    inflight_nxt    = inflight_r;
    busy_client_nxt = busy_client_r;
    drop_nxt        = drop_r;
    done_nxt        = done_r;
    done_client_nxt = done_client_r;
    srch_cnt_nxt    = (state_r == sdrs_pkg::ST_SEARCH) ? srch_cnt_r + 1'b1 : '0;

    if (accept) begin
      drop_nxt        = (in_kind == sdrs_pkg::KIND_REQ) && full;
      done_nxt        = (in_kind == sdrs_pkg::KIND_DONE) && inflight_r;
      done_client_nxt = '0;
      if (ctl.append_en) count_nxt = count_r + 1'b1;
      if ((in_kind == sdrs_pkg::KIND_DONE) && inflight_r) begin
        done_client_nxt = busy_client_r;
        inflight_nxt    = 1'b0;
        busy_client_nxt = '0;
      end
    end
    if (do_park) head_nxt = '0;
    if (do_pick) begin
      head_nxt        = sel.ent.addr;
      going_up_nxt    = use_up;
      inflight_nxt    = 1'b1;
      busy_client_nxt = sel.ent.client;
      count_nxt       = count_r - 1'b1;
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    out_valid_nxt       = fin_short || do_pick;
    out_disp_nxt        = do_pick;
    out_ent_nxt         = do_pick ? sel.ent : '0;
    out_done_nxt        = done_r;
    out_done_client_nxt = done_client_r;
    out_parked_nxt      = do_park;
    out_head_nxt        = head_nxt;
    out_drop_nxt        = drop_r;
    out_pend_nxt        = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sdrs_pkg::ST_IDLE;
      count_r       <= '0;
      head_r        <= '0;
      going_up_r    <= 1'b1;
      inflight_r    <= 1'b0;
      busy_client_r <= '0;
      srch_cnt_r    <= '0;
      drop_r        <= 1'b0;
      done_r        <= 1'b0;
      done_client_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      head_r        <= head_nxt;
      going_up_r    <= going_up_nxt;
      inflight_r    <= inflight_nxt;
      busy_client_r <= busy_client_nxt;
      srch_cnt_r    <= srch_cnt_nxt;
      drop_r        <= drop_nxt;
      done_r        <= done_nxt;
      done_client_r <= done_client_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_disp_r        <= out_disp_nxt;
      out_ent_r         <= out_ent_nxt;
      out_done_r        <= out_done_nxt;
      out_done_client_r <= out_done_client_nxt;
      out_parked_r      <= out_parked_nxt;
      out_head_r        <= out_head_nxt;
      out_drop_r        <= out_drop_nxt;
      out_pend_r        <= out_pend_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dispatched  = out_disp_r;
  assign out_disp_addr   = out_ent_r.addr;
  assign out_disp_client = out_ent_r.client;
  assign out_disp_write  = out_ent_r.wr;
  assign out_done_valid  = out_done_r;
  assign out_done_client = out_done_client_r;
  assign out_parked      = out_parked_r;
  assign out_head_now    = out_head_r;
  assign out_dropped     = out_drop_r;
  assign out_pending_now = out_pend_r;

  // ---------------- checks ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count above queue depth");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdrs_pkg::ST_PICK) |-> (up_w[QUEUE_DEPTH].found || dn_w[QUEUE_DEPTH].found))
    else $error("dispatch search found no candidate");

  a_disp_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_disp_r) |-> inflight_r)
    else $error("dispatched item without in-flight request");

  a_park_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_parked_r) |-> (out_head_r == '0 && out_pend_r == '0 && !out_disp_r))
    else $error("parked result with nonzero head or pending items");

  a_pick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdrs_pkg::ST_PICK) |=> (out_valid_r && out_disp_r && head_r == out_ent_r.addr))
    else $error("dispatch not reported or head not moved");

endmodule

>>> tb/testbench.sv
// testbench for scan_disk_request_scheduler_core: directed and random request/done items
// checked against an elevator scheduling predictor in a small scoreboard class
// depends on sdrs_pkg and the scheduler core rtl
`timescale 1ns / 1ps

module testbench;

  localparam int QDEPTH    = 16;
  localparam int NBLOCKS   = 1024;
  localparam int QUIET_MAX = 4000;
  localparam int N_RANDOM  = 680;
  localparam int AW        = sdrs_pkg::ADDR_W;
  localparam int CW        = sdrs_pkg::CLIENT_W;

  typedef struct packed {
    logic          dispatched;
    logic [AW-1:0] disp_addr;
    logic [CW-1:0] disp_client;
    logic          disp_write;
    logic          done_valid;
    logic [CW-1:0] done_client;
    logic          parked;
    logic [AW-1:0] head_now;
    logic          dropped;
    logic [4:0]    pending_now;
  } sched_step_t;

  class elevator_checker;
    logic [AW-1:0] q_addr [QDEPTH];
    logic [CW-1:0] q_client [QDEPTH];
    logic          q_wr [QDEPTH];
    int            n_pend;
    logic [AW-1:0] head;
    bit            sweep_up;
    bit            in_flight;
    logic [CW-1:0] flight_client;
    sched_step_t   predicted [$];
    bit            failed;
    int            n_errors;

    function new();
      n_pend = 0;
      head = '0;
      sweep_up = 1'b1;
      in_flight = 1'b0;
      flight_client = '0;
      failed = 1'b0;
      n_errors = 0;
    endfunction

    // nearest pending address at or beyond the head, earliest arrival on ties
    function int nearest(bit up);
      int best;
      int best_d;
      int d;
      best = -1;
      best_d = 0;
      for (int i = 0; i < n_pend; i++) begin
        if (up) begin
          if (q_addr[i] < head) continue;
          d = int'(q_addr[i]) - int'(head);
        end else begin
          if (q_addr[i] > head) continue;
          d = int'(head) - int'(q_addr[i]);
        end
        if (best < 0 || d < best_d) begin
          best = i;
          best_d = d;
        end
      end
      return best;
    endfunction

    function void accept_item(logic kind, logic [AW-1:0] addr,
                              logic [CW-1:0] client, logic wr);
      sched_step_t r;
      int idx;
      r = '0;
      if (kind == sdrs_pkg::KIND_REQ) begin
        if (n_pend < QDEPTH) begin
          if (int'(addr) >= NBLOCKS) addr = AW'(NBLOCKS - 1);
          q_addr[n_pend] = addr;
          q_client[n_pend] = client;
          q_wr[n_pend] = wr;
          n_pend++;
        end else begin
          r.dropped = 1'b1;
        end
      end else if (in_flight) begin
        r.done_valid = 1'b1;
        r.done_client = flight_client;
        in_flight = 1'b0;
        flight_client = '0;
      end
      if (!in_flight) begin
        if (n_pend > 0) begin
          idx = nearest(sweep_up);
          if (idx < 0) begin
            sweep_up = !sweep_up;
            idx = nearest(sweep_up);
          end
          r.dispatched = 1'b1;
          r.disp_addr = q_addr[idx];
          r.disp_client = q_client[idx];
          r.disp_write = q_wr[idx];
          head = q_addr[idx];
          in_flight = 1'b1;
          flight_client = q_client[idx];
          // close the gap, arrival order kept
          for (int i = idx; i + 1 < n_pend; i++) begin
            q_addr[i] = q_addr[i + 1];
            q_client[i] = q_client[i + 1];
            q_wr[i] = q_wr[i + 1];
          end
          n_pend--;
        end else begin
          head = '0;
          r.parked = 1'b1;
        end
      end
      r.head_now = head;
      r.pending_now = 5'(n_pend);
      predicted.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failed = 1'b1;
        n_errors++;
        if (n_errors <= 100)
          $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(sched_step_t got);
      sched_step_t want;
      if (predicted.size() == 0) begin
        failed = 1'b1;
        n_errors++;
        if (n_errors <= 100)
          $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        return;
      end
      want = predicted.pop_front();
      compare_field("dispatched", 32'(want.dispatched), 32'(got.dispatched));
      compare_field("disp_addr", 32'(want.disp_addr), 32'(got.disp_addr));
      compare_field("disp_client", 32'(want.disp_client), 32'(got.disp_client));
      compare_field("disp_write", 32'(want.disp_write), 32'(got.disp_write));
      compare_field("done_valid", 32'(want.done_valid), 32'(got.done_valid));
      compare_field("done_client", 32'(want.done_client), 32'(got.done_client));
      compare_field("parked", 32'(want.parked), 32'(got.parked));
      compare_field("head_now", 32'(want.head_now), 32'(got.head_now));
      compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
      compare_field("pending_now", 32'(want.pending_now), 32'(got.pending_now));
    endfunction

    function int outstanding();
      return predicted.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic          in_kind;
  logic [AW-1:0] in_req_addr;
  logic [CW-1:0] in_req_client;
  logic          in_req_write;
  logic          out_valid;
  logic          out_dispatched;
  logic [AW-1:0] out_disp_addr;
  logic [CW-1:0] out_disp_client;
  logic          out_disp_write;
  logic          out_done_valid;
  logic [CW-1:0] out_done_client;
  logic          out_parked;
  logic [AW-1:0] out_head_now;
  logic          out_dropped;
  logic [4:0]    out_pending_now;

  elevator_checker chk;
  bit              idle_on;
  logic [AW-1:0]   recent_addr;
  int              quiet_cycles;
  int              fill_addr [14];

  always #2 clk = ~clk;

  scan_disk_request_scheduler_core #(
    .QUEUE_DEPTH(QDEPTH),
    .DISK_BLOCKS(NBLOCKS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_req_addr    (in_req_addr),
    .in_req_client  (in_req_client),
    .in_req_write   (in_req_write),
    .out_valid      (out_valid),
    .out_dispatched (out_dispatched),
    .out_disp_addr  (out_disp_addr),
    .out_disp_client(out_disp_client),
    .out_disp_write (out_disp_write),
    .out_done_valid (out_done_valid),
    .out_done_client(out_done_client),
    .out_parked     (out_parked),
    .out_head_now   (out_head_now),
    .out_dropped    (out_dropped),
    .out_pending_now(out_pending_now)
  );

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_item(logic kind, logic [AW-1:0] addr,
                           logic [CW-1:0] client, logic wr);
    int gap;
    if (idle_on && $urandom_range(99) < 8) begin
      start = 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_kind = kind;
    in_req_addr = addr;
    in_req_client = client;
    in_req_write = wr;
    do @(posedge clk); while (busy !== 1'b0);
    chk.accept_item(kind, addr, client, wr);
    if (kind == sdrs_pkg::KIND_REQ) recent_addr = addr;
    @(negedge clk);
  endtask

  // ends, a repeat of a recent address for ties, or anything
  function automatic logic [AW-1:0] pick_addr();
    case ($urandom_range(7))
      0: return '0;
      1: return AW'(NBLOCKS - 1);
      2, 3: return recent_addr;
      default: return AW'($urandom_range(NBLOCKS - 1));
    endcase
  endfunction

  always @(posedge clk) begin
    sched_step_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got.dispatched = out_dispatched;
      got.disp_addr = out_disp_addr;
      got.disp_client = out_disp_client;
      got.disp_write = out_disp_write;
      got.done_valid = out_done_valid;
      got.done_client = out_done_client;
      got.parked = out_parked;
      got.head_now = out_head_now;
      got.dropped = out_dropped;
      got.pending_now = out_pending_now;
      chk.check_result(got);
    end
  end

  // stall watchdog: cycles in which neither an item nor a result moves
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int n_sent;
    int req_pct;
    int burst_len;
    chk = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = sdrs_pkg::KIND_REQ;
    in_req_addr = '0;
    in_req_client = '0;
    in_req_write = 1'b0;
    idle_on = 1'b1;
    recent_addr = '0;
    quiet_cycles = 0;
    fill_addr = '{0, 1023, 300, 300, 5, 1000, 600, 1, 1022, 511, 513, 0, 700, 256};
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // completion with nothing in flight parks the head
    send_item(sdrs_pkg::KIND_DONE, 10'd0, 8'd0, 1'b0);
    send_item(sdrs_pkg::KIND_REQ, 10'd0, 8'd0, 1'b0);
    send_item(sdrs_pkg::KIND_REQ, 10'd1023, 8'd255, 1'b1);
    send_item(sdrs_pkg::KIND_REQ, 10'd512, 8'd17, 1'b0);
    send_item(sdrs_pkg::KIND_REQ, 10'd512, 8'd18, 1'b1);
    send_item(sdrs_pkg::KIND_DONE, 10'd1023, 8'd255, 1'b1);
    // fill the queue while a request is in flight, then overflow it
    for (int i = 0; i < 14; i++)
      send_item(sdrs_pkg::KIND_REQ, AW'(fill_addr[i]), CW'(i + 32), i[0]);
    send_item(sdrs_pkg::KIND_REQ, 10'd99, 8'd99, 1'b1);
    repeat (3) send_item(sdrs_pkg::KIND_DONE, 10'd0, 8'd0, 1'b0);

    // bursts with a varying request share so the queue both fills and drains
    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      case ($urandom_range(3))
        0: req_pct = 25;
        1: req_pct = 50;
        2: req_pct = 65;
        default: req_pct = 85;
      endcase
      burst_len = $urandom_range(60, 15);
      repeat (burst_len) begin
        idle_on = !(n_sent >= 250 && n_sent < 400);
        if ($urandom_range(99) < req_pct)
          send_item(sdrs_pkg::KIND_REQ, pick_addr(), CW'($urandom_range(255)),
                    1'($urandom_range(1)));
        else
          send_item(sdrs_pkg::KIND_DONE, AW'($urandom_range(NBLOCKS - 1)),
                    CW'($urandom_range(255)), 1'($urandom_range(1)));
        n_sent++;
      end
    end
    start = 1'b0;

    while (chk.outstanding() != 0) @(posedge clk);
    repeat (QDEPTH + 4) @(posedge clk);
    if (chk.failed)
      $display("Mismatches found");
    else
      $display("No mismatches found");
    $finish;
  end

endmodule

>>> scan_disk_request_scheduler_core.f
hw/rtl/sdrs_pkg.sv
hw/rtl/sdrs_cell.sv
hw/rtl/scan_disk_request_scheduler_core.sv
tb/testbench.sv
